/* rtl/pwg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pwg_pkg
// Shared constants, register indices, waveform codes and polynomial tables
// for the periodic waveform generator.
// ----------------------------------------------------------------------------
package pwg_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CFG_IDX_W     = 3;

	// configuration register indices
	localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CYCLE_START = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CYCLE_END   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LEVEL  = 3'd4;

	// waveform codes
	localparam logic [2:0] WAVE_SINE     = 3'd0;
	localparam logic [2:0] WAVE_COSINE   = 3'd1;
	localparam logic [2:0] WAVE_SAW      = 3'd2;
	localparam logic [2:0] WAVE_INV_SAW  = 3'd3;
	localparam logic [2:0] WAVE_TRIANGLE = 3'd4;
	localparam logic [2:0] WAVE_SQUARE   = 3'd5;

	// divider: integer bits give the remainder, fraction bits give f
	localparam int INT_STEPS  = 32;
	localparam int FRAC_STEPS = 31;
	localparam int DIV_STEPS  = INT_STEPS + FRAC_STEPS;

	localparam int TAY_ITERS = 7;

	localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

	// iteration i divides by k = (2j)(2j+1), j = 7 - i, as k = 2^shift * odd
	function automatic int tay_shift(input int i);
		int r;
		case (i)
			0: r = 1;
			1: r = 2;
			2: r = 1;
			3: r = 3;
			4: r = 1;
			5: r = 2;
			default: r = 1;
		endcase
		return r;
	endfunction

	function automatic int tay_odd(input int i);
		int r;
		case (i)
			0: r = 105;
			1: r = 39;
			2: r = 55;
			3: r = 9;
			4: r = 21;
			5: r = 5;
			default: r = 3;
		endcase
		return r;
	endfunction

	// floor(2^32 / odd)
	function automatic logic [30:0] tay_recip(input int i);
		logic [30:0] r;
		case (i)
			0: r = 31'd40904450;
			1: r = 31'd110127366;
			2: r = 31'd78090314;
			3: r = 31'd477218588;
			4: r = 31'd204522252;
			5: r = 31'd858993459;
			default: r = 31'd1431655765;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/periodic_waveform_generator_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_waveform_generator_core
// Pipelined LFO-style waveform generator: one sample per position.
// ----------------------------------------------------------------------------
// Usage
//   An input transaction is taken at a rising edge with start high and busy
//   low; busy stays low, so a new position may be given in every cycle.
//   Each result is shown on sample, rounded and degenerate for one cycle
//   with done high; the receiver takes it in that cycle and cannot stall.
//   Configuration is written through cfg_we / cfg_index / cfg_wdata, one
//   register per edge, while no transaction is in flight; unknown indices
//   are ignored.
// Timing
//   A 63 step restoring divider (one quotient bit per stage) forms the cycle
//   fraction, the sine polynomial takes seven three-stage iterations, and the
//   level scaling multiplier is split over two stages. Throughput is one
//   transaction per cycle.
// Reset
//   arst_n clears every valid bit and loads the register reset values;
//   results in flight are dropped.
// ----------------------------------------------------------------------------
module periodic_waveform_generator_core #(
	parameter int FRAC_BITS = pwg_pkg::FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic signed [31:0]             position,
	input  wire logic                           cfg_we,
	input  wire logic [pwg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [31:0]                    cfg_wdata,
	output logic                                done,
	output logic signed [31:0]                  sample,
	output logic signed [15:0]                  rounded,
	output logic                                degenerate
);
	import pwg_pkg::*;

	// ------------------------------------------------------------------
	// configuration registers and derived values
	// ------------------------------------------------------------------
	logic [2:0]         waveform_q;
	logic signed [31:0] start_q, end_q, low_q, high_q;
	logic [31:0]        den_q;
	logic               len_neg_q, len_zero_q;
	logic signed [32:0] diff_q;

	logic signed [31:0] nx_start, nx_end, nx_low, nx_high;
	logic signed [32:0] nx_len, nx_diff;

	always_comb begin
		nx_start = (cfg_index == REG_CYCLE_START) ? cfg_wdata : start_q;
		nx_end   = (cfg_index == REG_CYCLE_END)   ? cfg_wdata : end_q;
		nx_low   = (cfg_index == REG_LOW_LEVEL)   ? cfg_wdata : low_q;
		nx_high  = (cfg_index == REG_HIGH_LEVEL)  ? cfg_wdata : high_q;
		nx_len   = 33'(nx_end) - 33'(nx_start);
		nx_diff  = 33'(nx_high) - 33'(nx_low);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q <= WAVE_SINE;
			start_q    <= '0;
			end_q      <= 32'sd65536;
			low_q      <= '0;
			high_q     <= 32'sd65536;
			den_q      <= 32'd65536;
			len_neg_q  <= 1'b0;
			len_zero_q <= 1'b0;
			diff_q     <= 33'sd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WAVEFORM:    waveform_q <= cfg_wdata[2:0];
				REG_CYCLE_START: start_q    <= cfg_wdata;
				REG_CYCLE_END:   end_q      <= cfg_wdata;
				REG_LOW_LEVEL:   low_q      <= cfg_wdata;
				REG_HIGH_LEVEL:  high_q     <= cfg_wdata;
				default: ;
			endcase
			den_q      <= nx_len[32] ? 32'(-nx_len) : nx_len[31:0];
			len_neg_q  <= nx_len[32];
			len_zero_q <= (nx_len == '0);
			diff_q     <= nx_diff;
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// ------------------------------------------------------------------
	// s1 / s2: signed distance into the cycle, then restoring division
	// ------------------------------------------------------------------
	logic               dv_vld_s2 [0:DIV_STEPS];
	logic [31:0]        dv_rem_s2 [0:DIV_STEPS];
	logic [DIV_STEPS-1:0] dv_dq_s2 [0:DIV_STEPS];
	logic               dv_neg_s2 [0:DIV_STEPS];
	logic               dv_mz_s2  [0:DIV_STEPS];

	logic signed [32:0] num_s1;

	always_comb begin
		num_s1 = len_neg_q ? (33'(start_q) - 33'(position))
		                   : (33'(position) - 33'(start_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s2[0] <= 1'b0;
		end else begin
			dv_vld_s2[0] <= accept;
		end
	end

	always_ff @(posedge clk) begin
		dv_rem_s2[0] <= '0;
		dv_dq_s2[0]  <= {(num_s1[32] ? 32'(-num_s1) : num_s1[31:0]),
		                 {FRAC_STEPS{1'b0}}};
		dv_neg_s2[0] <= num_s1[32];
		dv_mz_s2[0]  <= 1'b0;
	end

	for (genvar g = 1; g <= DIV_STEPS; g++) begin : g_div
		logic [32:0] trial;
		logic        ge;
		logic [32:0] sub;

		always_comb begin
			trial = {dv_rem_s2[g-1], dv_dq_s2[g-1][DIV_STEPS-1]};
			ge    = (trial >= {1'b0, den_q});
			sub   = trial - {1'b0, den_q};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s2[g] <= 1'b0;
			end else begin
				dv_vld_s2[g] <= dv_vld_s2[g-1];
			end
		end

		always_ff @(posedge clk) begin
			dv_rem_s2[g] <= ge ? sub[31:0] : trial[31:0];
			dv_dq_s2[g]  <= {dv_dq_s2[g-1][DIV_STEPS-2:0], ge};
			dv_neg_s2[g] <= dv_neg_s2[g-1];
			// remainder of the integer part decides the wrap of negative distances
			if (g == INT_STEPS) begin
				dv_mz_s2[g] <= ge ? (sub[31:0] == '0) : (trial[31:0] == '0);
			end else begin
				dv_mz_s2[g] <= dv_mz_s2[g-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// s3: cycle fraction f in Q0.31, floored
	// ------------------------------------------------------------------
	logic        vld_s3;
	logic [30:0] f_s3;
	logic [31:0] fneg;

	always_comb begin
		fneg = 32'h8000_0000 - {1'b0, dv_dq_s2[DIV_STEPS][FRAC_STEPS-1:0]}
		     - 32'(dv_rem_s2[DIV_STEPS] != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= dv_vld_s2[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (!dv_neg_s2[DIV_STEPS]) begin
			f_s3 <= dv_dq_s2[DIV_STEPS][FRAC_STEPS-1:0];
		end else if (dv_mz_s2[DIV_STEPS]) begin
			f_s3 <= '0;
		end else begin
			f_s3 <= fneg[30:0];
		end
	end

	// ------------------------------------------------------------------
	// s4: simple shapes and quarter-wave angle for sine and cosine
	// ------------------------------------------------------------------
	localparam logic [30:0] HALF_F = 31'h4000_0000;

	logic        vld_s4, up_s4;
	logic [31:0] sh_s4;
	logic [29:0] pp_s4;
	logic [31:0] sh_c;
	logic [30:0] fsel;
	logic [32:0] tri_dn;

	always_comb begin
		tri_dn = 33'h1_0000_0000 - {1'b0, f_s3, 1'b0};
		case (waveform_q)
			WAVE_SAW:      sh_c = {1'b0, f_s3};
			WAVE_INV_SAW:  sh_c = (f_s3 == '0) ? '0 : 32'h8000_0000 - {1'b0, f_s3};
			WAVE_TRIANGLE: sh_c = (f_s3 < HALF_F) ? {f_s3, 1'b0} : tri_dn[31:0];
			WAVE_SQUARE: begin
				if (len_neg_q) begin
					sh_c = (f_s3 <= HALF_F) ? 32'h8000_0000 : '0;
				end else begin
					sh_c = (f_s3 >= HALF_F) ? 32'h8000_0000 : '0;
				end
			end
			default: sh_c = '0;
		endcase
		fsel = (waveform_q == WAVE_COSINE) ? (f_s3 + 31'h2000_0000) : f_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		sh_s4 <= sh_c;
		up_s4 <= ~fsel[30];
		pp_s4 <= fsel[29] ? (30'h2000_0000 - {1'b0, fsel[28:0]}) : {1'b0, fsel[28:0]};
	end

	// ------------------------------------------------------------------
	// s5 / s6: angle x in Q30 and x^2
	// ------------------------------------------------------------------
	logic        vld_s5, up_s5, vld_s6, up_s6;
	logic [31:0] sh_s5, sh_s6, x2_s6;
	logic [30:0] x_s5, x_s6;
	logic [60:0] xp;
	logic [61:0] x2p;

	always_comb begin
		xp  = 61'(pp_s4) * 61'(HALF_PI_Q30);
		x2p = 62'(x_s5) * 62'(x_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		x_s5  <= xp[59:29];
		sh_s5 <= sh_s4;
		up_s5 <= up_s4;
		x2_s6 <= x2p[61:30];
		x_s6  <= x_s5;
		sh_s6 <= sh_s5;
		up_s6 <= up_s5;
	end

	// ------------------------------------------------------------------
	// s7: Horner steps t = 1 - x^2 t / k, three stages each
	// ------------------------------------------------------------------
	logic        ty_vld_s7 [0:TAY_ITERS];
	logic [30:0] ty_t_s7   [0:TAY_ITERS];
	logic [30:0] ty_x_s7   [0:TAY_ITERS];
	logic [31:0] ty_x2_s7  [0:TAY_ITERS];
	logic [31:0] ty_sh_s7  [0:TAY_ITERS];
	logic        ty_up_s7  [0:TAY_ITERS];

	assign ty_vld_s7[0] = vld_s6;
	assign ty_t_s7[0]   = ONE_Q30;
	assign ty_x_s7[0]   = x_s6;
	assign ty_x2_s7[0]  = x2_s6;
	assign ty_sh_s7[0]  = sh_s6;
	assign ty_up_s7[0]  = up_s6;

	for (genvar i = 0; i < TAY_ITERS; i++) begin : g_tay
		localparam int          SHIFT = 30 + tay_shift(i);
		localparam logic [6:0]  ODD   = 7'(tay_odd(i));
		localparam logic [30:0] RECIP = tay_recip(i);

		logic        a_vld, b_vld;
		logic [30:0] a_v, b_v, b_q0;
		logic [30:0] a_x, b_x;
		logic [31:0] a_x2, b_x2, a_sh, b_sh;
		logic        a_up, b_up;
		logic [62:0] prod;
		logic [61:0] rprod;
		logic [37:0] qb;
		logic [31:0] rem;
		logic [30:0] q;

		always_comb begin
			prod  = 63'(ty_x2_s7[i]) * 63'(ty_t_s7[i]);
			rprod = 62'(a_v) * 62'(RECIP);
			qb    = 38'(b_q0) * 38'(ODD);
			rem   = 32'(b_v) - qb[31:0];
			q     = (rem >= 32'(ODD)) ? (b_q0 + 31'd1) : b_q0;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				a_vld            <= 1'b0;
				b_vld            <= 1'b0;
				ty_vld_s7[i+1]   <= 1'b0;
			end else begin
				a_vld            <= ty_vld_s7[i];
				b_vld            <= a_vld;
				ty_vld_s7[i+1]   <= b_vld;
			end
		end

		always_ff @(posedge clk) begin
			a_v  <= 31'(prod >> SHIFT);
			a_x  <= ty_x_s7[i];
			a_x2 <= ty_x2_s7[i];
			a_sh <= ty_sh_s7[i];
			a_up <= ty_up_s7[i];
			// reciprocal estimate is low by at most one
			b_q0 <= {1'b0, rprod[61:32]};
			b_v  <= a_v;
			b_x  <= a_x;
			b_x2 <= a_x2;
			b_sh <= a_sh;
			b_up <= a_up;
			ty_t_s7[i+1]  <= ONE_Q30 - q;
			ty_x_s7[i+1]  <= b_x;
			ty_x2_s7[i+1] <= b_x2;
			ty_sh_s7[i+1] <= b_sh;
			ty_up_s7[i+1] <= b_up;
		end
	end

	// ------------------------------------------------------------------
	// s8: sine magnitude, shape select
	// ------------------------------------------------------------------
	logic        vld_s8;
	logic [31:0] shape_s8;
	logic [61:0] sp;
	logic [30:0] mag;
	logic [31:0] sine_sh;

	always_comb begin
		sp      = 62'(ty_x_s7[TAY_ITERS]) * 62'(ty_t_s7[TAY_ITERS]);
		mag     = (sp[61:30] > 32'(ONE_Q30)) ? ONE_Q30 : sp[60:30];
		sine_sh = ty_up_s7[TAY_ITERS] ? (32'(ONE_Q30) + 32'(mag))
		                              : (32'(ONE_Q30) - 32'(mag));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else begin
			vld_s8 <= ty_vld_s7[TAY_ITERS];
		end
	end

	always_ff @(posedge clk) begin
		if (waveform_q == WAVE_SINE || waveform_q == WAVE_COSINE) begin
			shape_s8 <= sine_sh;
		end else begin
			shape_s8 <= ty_sh_s7[TAY_ITERS];
		end
	end

	// ------------------------------------------------------------------
	// s9..s12: low + (high - low) * shape / 2^31, rounded half up
	// ------------------------------------------------------------------
	logic               vld_s9, vld_s10, vld_s11, vld_s12;
	logic signed [49:0] plo_s9, plo_s10, phi_s10;
	logic [15:0]        shhi_s9;
	logic signed [65:0] acc_s11;
	logic signed [31:0] samp_s12;
	logic signed [49:0] plo_c, phi_c;
	logic signed [65:0] acc_c;
	logic signed [35:0] sum_c;

	always_comb begin
		plo_c = 50'(diff_q * $signed({1'b0, shape_s8[15:0]}));
		phi_c = 50'(diff_q * $signed({1'b0, shhi_s9}));
		acc_c = (66'(phi_s10) <<< 16) + 66'(plo_s10) + (66'sd1 <<< 30);
		sum_c = 36'(low_q) + 36'(acc_s11 >>> 31);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else begin
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		plo_s9   <= plo_c;
		shhi_s9  <= shape_s8[31:16];
		plo_s10  <= plo_s9;
		phi_s10  <= phi_c;
		acc_s11  <= acc_c;
		if (len_zero_q || waveform_q > WAVE_SQUARE) begin
			samp_s12 <= '0;
		end else begin
			samp_s12 <= sum_c[31:0];
		end
	end

	// ------------------------------------------------------------------
	// s13: integer rounding half away from zero, saturated; outputs
	// ------------------------------------------------------------------
	logic              done_q, degen_q;
	logic signed [31:0] sample_q;
	logic signed [15:0] rounded_q;
	logic [32:0]       rmag_in, rsum, rmag;
	logic [15:0]       rnd_c;
	logic              sneg;

	always_comb begin
		sneg    = samp_s12[31];
		rmag_in = sneg ? (33'd0 - 33'(samp_s12)) : 33'(samp_s12);
		rsum    = rmag_in + (33'd1 << (FRAC_BITS - 1));
		rmag    = rsum >> FRAC_BITS;
		if (sneg) begin
			rnd_c = (rmag > 33'd32768) ? 16'h8000 : (16'd0 - rmag[15:0]);
		end else begin
			rnd_c = (rmag > 33'd32767) ? 16'h7fff : rmag[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		sample_q  <= samp_s12;
		rounded_q <= rnd_c;
		degen_q   <= len_zero_q;
	end

	assign done       = done_q;
	assign sample     = sample_q;
	assign rounded    = rounded_q;
	assign degenerate = degen_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_shape_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 |-> shape_s8 <= 32'h8000_0000)
		else $error("shape above one");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> x_s5 <= HALF_PI_Q30)
		else $error("quarter-wave angle above pi/2");

	a_round_sign: assert property (@(posedge clk) disable iff (!arst_n)
		done && !sample[31] |-> !rounded[15])
		else $error("rounded result has wrong sign");

endmodule
`default_nettype wire

/* tb/tb_periodic_waveform_generator_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_periodic_waveform_generator_core
// Self-checking bench: drives positions through the generator under a range
// of waveform, cycle and level settings and compares every sample against a
// bit-exact behavioural predictor, with random gaps in the input stream.
// ----------------------------------------------------------------------------
module tb_periodic_waveform_generator_core;
	import pwg_pkg::*;

	localparam int LATENCY = 95;

	typedef struct {
		logic signed [31:0] sample;
		logic signed [15:0] rounded;
		logic               degenerate;
	} wave_result_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] position;
	logic               cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]        cfg_wdata;
	logic               done;
	logic signed [31:0] sample;
	logic signed [15:0] rounded;
	logic               degenerate;

	int errors;
	int n_items;
	int n_results;
	int idle_pct;

	// shadow copy of the configuration registers
	logic [2:0]         sh_wave;
	logic signed [31:0] sh_start, sh_end, sh_low, sh_high;

	periodic_waveform_generator_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.position(position), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .done(done), .sample(sample),
		.rounded(rounded), .degenerate(degenerate)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch on %s: got %0d, expected %0d (result %0d)",
			what, got, want, n_results);
		errors++;
	endtask

	// sin over a quarter wave, p in [0, 2^29], Q30
	function automatic longint unsigned quarter_sin(input longint unsigned p);
		longint unsigned x, x2, t, s, k;
		x = (p * 64'd1686629713) >> 29;
		x2 = (x * x) >> 30;
		t = 64'd1 << 30;
		for (int j = 7; j >= 1; j--) begin
			k = (2 * j) * (2 * j + 1);
			t = (64'd1 << 30) - ((x2 * t) >> 30) / k;
		end
		s = (x * t) >> 30;
		return (s > (64'd1 << 30)) ? (64'd1 << 30) : s;
	endfunction

	function automatic longint unsigned sine_shape(input longint unsigned f);
		longint unsigned q, p, m;
		q = f >> 29;
		p = f & ((64'd1 << 29) - 1);
		m = quarter_sin(q[0] ? (64'd1 << 29) - p : p);
		return (q < 2) ? (64'd1 << 30) + m : (64'd1 << 30) - m;
	endfunction

	function automatic wave_result_t predict_wave(input logic signed [31:0] pos);
		wave_result_t r;
		longint sv_start, len, diff, num, den, rem, smp, mag, rnd, prod;
		longint unsigned f, shape;
		sv_start = sh_start;
		len = longint'(sh_end) - sv_start;
		diff = longint'(sh_high) - longint'(sh_low);
		smp = 0;
		shape = 0;
		if (len != 0 && sh_wave <= WAVE_SQUARE) begin
			num = (len < 0) ? sv_start - pos : longint'(pos) - sv_start;
			den = (len < 0) ? -len : len;
			rem = num % den;
			if (rem < 0)
				rem += den;
			f = ($unsigned(rem) << 31) / $unsigned(den);
			case (sh_wave)
				WAVE_SINE:     shape = sine_shape(f);
				WAVE_COSINE:   shape = sine_shape((f + (64'd1 << 29)) & ((64'd1 << 31) - 1));
				WAVE_SAW:      shape = f;
				WAVE_INV_SAW:  shape = (f == 0) ? 0 : (64'd1 << 31) - f;
				WAVE_TRIANGLE: shape = (f < (64'd1 << 30)) ? 2 * f : (64'd1 << 32) - 2 * f;
				default: begin
					if (len > 0)
						shape = (f >= (64'd1 << 30)) ? (64'd1 << 31) : 0;
					else
						shape = (f <= (64'd1 << 30)) ? (64'd1 << 31) : 0;
				end
			endcase
			prod = diff * longint'(shape) + (64'sd1 << 30);
			smp = longint'(sh_low) + (prod >>> 31);
		end
		mag = (smp < 0) ? -smp : smp;
		rnd = (mag + 32768) >>> 16;
		if (smp < 0)
			rnd = -rnd;
		if (rnd > 32767)
			rnd = 32767;
		if (rnd < -32768)
			rnd = -32768;
		r.sample = smp[31:0];
		r.rounded = rnd[15:0];
		r.degenerate = (len == 0);
		return r;
	endfunction

	class wave_scoreboard;
		wave_result_t pending[$];

		function void note_position(input logic signed [31:0] pos);
			pending.push_back(predict_wave(pos));
		endfunction

		task check_result(input wave_result_t got);
			wave_result_t want;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
				return;
			end
			want = pending.pop_front();
			if (got.sample !== want.sample)
				report_mismatch("sample", got.sample, want.sample);
			if (got.rounded !== want.rounded)
				report_mismatch("rounded", got.rounded, want.rounded);
			if (got.degenerate !== want.degenerate)
				report_mismatch("degenerate", got.degenerate, want.degenerate);
		endtask
	endclass

	wave_scoreboard board = new();

	always @(posedge clk) begin
		wave_result_t got;
		if (arst_n && done) begin
			got.sample = sample;
			got.rounded = rounded;
			got.degenerate = degenerate;
			board.check_result(got);
			n_results++;
		end
	end

	task automatic wait_drained();
		start <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_WAVEFORM:    sh_wave = val[2:0];
			REG_CYCLE_START: sh_start = val;
			REG_CYCLE_END:   sh_end = val;
			REG_LOW_LEVEL:   sh_low = val;
			REG_HIGH_LEVEL:  sh_high = val;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [2:0] w, input logic [31:0] cs, input logic [31:0] ce,
			input logic [31:0] lo, input logic [31:0] hi);
		wait_drained();
		write_reg(REG_WAVEFORM, {29'd0, w});
		write_reg(REG_CYCLE_START, cs);
		write_reg(REG_CYCLE_END, ce);
		write_reg(REG_LOW_LEVEL, lo);
		write_reg(REG_HIGH_LEVEL, hi);
		cfg_we <= 1'b0;
	endtask

	// one transaction, with an optional random gap first
	task automatic send_position(input logic signed [31:0] pos);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		position <= pos;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_position(pos);
		n_items++;
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_config();
		logic [31:0] cs, ce;
		cs = rand_word();
		ce = ($urandom_range(9) == 0) ? cs : rand_word();
		set_config(3'($urandom_range(7)), cs, ce, rand_word(), rand_word());
	endtask

	task automatic random_burst(input int count);
		logic signed [31:0] pos;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(3) == 0)
				pos = $urandom;
			else
				pos = sh_start + $signed($urandom_range(32'h0003_0000)) - 32'sh0001_0000;
			send_position(pos);
		end
	endtask

	initial begin
		errors = 0;
		n_items = 0;
		n_results = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		position = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		sh_wave = WAVE_SINE;
		sh_start = 0;
		sh_end = 32'sh0001_0000;
		sh_low = 0;
		sh_high = 32'sh0001_0000;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, quadrant points and field extremes
		send_position(32'sh0000_0000);
		send_position(32'sh0000_4000);
		send_position(32'sh0000_8000);
		send_position(32'sh0000_c000);
		send_position(32'sh7fff_ffff);
		send_position(32'sh8000_0000);
		// every waveform with swapped ends and levels
		for (int w = 0; w < 8; w++) begin
			set_config(3'(w), 32'sh0001_0000, 32'sh0000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
			send_position(32'sh0000_8000);
			send_position(32'sh0000_2000);
		end
		// zero-length cycle, equal levels, full-range cycle
		set_config(WAVE_SAW, 32'sh0000_1234, 32'sh0000_1234, 0, 32'sh0001_0000);
		send_position(32'sh0000_1234);
		set_config(WAVE_TRIANGLE, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh0005_0000, 32'sh0005_0000);
		send_position(32'sh0000_0000);
		set_config(WAVE_SQUARE, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
		send_position(32'sh7fff_ffff);
		send_position(32'sh0000_0000);
		// unknown register index must be ignored
		wait_drained();
		write_reg(3'd7, 32'hdead_beef);
		cfg_we <= 1'b0;
		send_position(32'sh0000_0000);

		for (int phase = 0; phase < 16; phase++) begin
			case (phase % 4)
				0: idle_pct = 0;
				1: idle_pct = 84;
				2: idle_pct = 34;
				default: idle_pct = 0;
			endcase
			random_config();
			random_burst(24);
		end
		// sender holds off until the pipeline has emptied
		wait_drained();
		random_burst(8);

		fork
			wait_drained();
			begin
				repeat (LATENCY * 4 + 2000) @(posedge clk);
			end
		join_any
		disable fork;
		$display("covered %0d positions over 28 register settings, %0d samples checked",
			n_items, n_results);
		if (errors == 0 && board.pending.size() == 0)
			$display("** periodic_waveform_generator_core: PASSED **");
		else
			$display("** periodic_waveform_generator_core: FAILED **");
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout waiting for results");
		$display("** periodic_waveform_generator_core: FAILED **");
		$finish;
	end

endmodule
